@@ hw/rtl/sdp_pkg.sv @@
// ----------------------------------------------------------------------------
// sdp_pkg: shared types and constants for the stepper detent positioner
// Field widths, register map, reset values and the single-step helpers.
// ----------------------------------------------------------------------------
package sdp_pkg;

   // Width of the internal step counter
   localparam int POSITION_BITS = 12;
   // Fixed field widths of the request, response and register set
   localparam int PERIOD_W = 7;
   localparam int TARGET_W = 12;
   localparam int MASK_W   = 4;
   localparam int SLOT_W   = $clog2(MASK_W);
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Register reset values
   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST  = 7'd35;
   localparam logic [TARGET_W-1:0] TARGET_ONE_RST   = 12'd2000;
   localparam logic [TARGET_W-1:0] TARGET_TWO_RST   = 12'd3000;
   localparam logic [TARGET_W-1:0] TARGET_THREE_RST = 12'd3500;

   // Register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_STEP_PERIOD  = 2'd0,
      REG_TARGET_ONE   = 2'd1,
      REG_TARGET_TWO   = 2'd2,
      REG_TARGET_THREE = 2'd3
   } reg_index_type;

   // Request operation codes
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_POST = 1'b1
   } op_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] step_period;
      logic [TARGET_W-1:0] target_one;
      logic [TARGET_W-1:0] target_two;
      logic [TARGET_W-1:0] target_three;
   } cfg_type;

   typedef struct packed {
      logic              operation;
      logic [MASK_W-1:0] request_mask;
      logic              home_switch;
   } req_type;

   typedef struct packed {
      logic                step_toggle;
      logic                step_level;
      logic                direction;
      logic                enable_pulse;
      logic [TARGET_W-1:0] position;
      logic [MASK_W-1:0]   pending;
      logic                homing;
   } rsp_type;

   // Pipeline control from the top level to the core
   typedef struct packed {
      logic in_valid;
      logic advance;
   } ctrl_type;

   // Outcome of servicing one detent request
   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic                     moved;
      logic                     descend;
      logic                     arrived;
   } svc_type;

   // Saturate a register target to the step counter range
   function automatic logic [POSITION_BITS-1:0] clamp_target(
      input logic [TARGET_W-1:0] t
   );
      if (int'(t) > int'(POS_MAX)) begin
         return POS_MAX;
      end
      return POSITION_BITS'(t);
   endfunction

   // One unit of motion toward a target
   function automatic svc_type service_step(
      input logic [POSITION_BITS-1:0] pos,
      input logic [POSITION_BITS-1:0] target,
      input logic                     may_descend
   );
      svc_type r;
      r.position = pos;
      r.moved    = 1'b0;
      r.descend  = 1'b0;
      if (pos < target) begin
         r.moved    = 1'b1;
         r.position = pos + 1'b1;
      end else if (pos > target && may_descend) begin
         r.moved    = 1'b1;
         r.descend  = 1'b1;
         r.position = pos - 1'b1;
      end
      r.arrived = (r.position == target);
      return r;
   endfunction

endpackage

@@ hw/rtl/sdp_if.sv @@
// ----------------------------------------------------------------------------
// sdp_req_if / sdp_rsp_if: request and response channels
// Valid/ready channels carrying the positioner request and response fields.
// ----------------------------------------------------------------------------
interface sdp_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [sdp_pkg::MASK_W-1:0] request_mask;
   logic                      home_switch;

   modport source (output valid, operation, request_mask, home_switch, input ready);
   modport sink   (input valid, operation, request_mask, home_switch, output ready);
endinterface

interface sdp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         step_toggle;
   logic                         step_level;
   logic                         direction;
   logic                         enable_pulse;
   logic [sdp_pkg::TARGET_W-1:0] position;
   logic [sdp_pkg::MASK_W-1:0]   pending;
   logic                         homing;

   modport source (output valid, step_toggle, step_level, direction, enable_pulse,
                   position, pending, homing, input ready);
   modport sink   (input valid, step_toggle, step_level, direction, enable_pulse,
                   position, pending, homing, output ready);
endinterface

@@ hw/rtl/sdp_csr.sv @@
// ----------------------------------------------------------------------------
// sdp_csr: configuration register file
// APB-style write/read of step period and the three detent targets.
// ----------------------------------------------------------------------------
module sdp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sdp_pkg::ADDR_W-1:0]  paddr,
   input  logic [sdp_pkg::DATA_W-1:0]  pwdata,
   output logic [sdp_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output sdp_pkg::cfg_type            cfg
);

   sdp_pkg::cfg_type       cfg_ff, cfg_in;
   sdp_pkg::reg_index_type reg_index;
   logic                   wr_en;

   assign reg_index = sdp_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            sdp_pkg::REG_STEP_PERIOD:  cfg_in.step_period  = pwdata[sdp_pkg::PERIOD_W-1:0];
            sdp_pkg::REG_TARGET_ONE:   cfg_in.target_one   = pwdata[sdp_pkg::TARGET_W-1:0];
            sdp_pkg::REG_TARGET_TWO:   cfg_in.target_two   = pwdata[sdp_pkg::TARGET_W-1:0];
            sdp_pkg::REG_TARGET_THREE: cfg_in.target_three = pwdata[sdp_pkg::TARGET_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period  <= sdp_pkg::STEP_PERIOD_RST;
         cfg_ff.target_one   <= sdp_pkg::TARGET_ONE_RST;
         cfg_ff.target_two   <= sdp_pkg::TARGET_TWO_RST;
         cfg_ff.target_three <= sdp_pkg::TARGET_THREE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_index)
         sdp_pkg::REG_STEP_PERIOD:  prdata = sdp_pkg::DATA_W'(cfg_ff.step_period);
         sdp_pkg::REG_TARGET_ONE:   prdata = sdp_pkg::DATA_W'(cfg_ff.target_one);
         sdp_pkg::REG_TARGET_TWO:   prdata = sdp_pkg::DATA_W'(cfg_ff.target_two);
         sdp_pkg::REG_TARGET_THREE: prdata = sdp_pkg::DATA_W'(cfg_ff.target_three);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/sdp_core.sv @@
// ----------------------------------------------------------------------------
// sdp_core: positioner state and step logic
// Prescaler, homing, ordered detent servicing and the response register.
// ----------------------------------------------------------------------------
module sdp_core (
   input  logic              clock,
   input  logic              reset,
   input  sdp_pkg::cfg_type  cfg,
   input  sdp_pkg::ctrl_type ctrl,
   input  sdp_pkg::req_type  req,
   output sdp_pkg::rsp_type  rsp
);

   logic [sdp_pkg::PERIOD_W-1:0]      prescale_ff, prescale_in;
   logic [sdp_pkg::POSITION_BITS-1:0] position_ff, position_in;
   logic [sdp_pkg::MASK_W-1:0]        pending_ff, pending_in;
   logic                              homing_ff, homing_in;
   logic                              dir_ff, dir_in;
   logic                              level_ff, level_in;
   sdp_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              process;

   assign process = ctrl.in_valid && ctrl.advance;

   // Next state for one request
   always_comb begin
      logic [sdp_pkg::PERIOD_W-1:0]      count_sum;
      logic                              fire;
      logic                              toggle;
      logic                              enabled;
      logic [sdp_pkg::POSITION_BITS-1:0] tgt [sdp_pkg::MASK_W];
      logic [sdp_pkg::SLOT_W-1:0]        slot;
      sdp_pkg::svc_type                  svc;

      prescale_in = prescale_ff;
      position_in = position_ff;
      pending_in  = pending_ff;
      homing_in   = homing_ff;
      dir_in      = dir_ff;
      level_in    = level_ff;
      toggle      = 1'b0;
      enabled     = 1'b0;
      fire        = 1'b0;
      svc         = '0;
      slot        = '0;
      count_sum   = prescale_ff + 1'b1;

      tgt[0] = '0;
      tgt[1] = sdp_pkg::clamp_target(cfg.target_one);
      tgt[2] = sdp_pkg::clamp_target(cfg.target_two);
      tgt[3] = sdp_pkg::clamp_target(cfg.target_three);

      if (req.operation == sdp_pkg::OP_POST) begin
         pending_in = pending_ff | req.request_mask;
      end else begin
         fire        = (count_sum >= cfg.step_period);
         prescale_in = fire ? '0 : count_sum;
      end

      // Homing: one step per fired tick until the switch closes
      if (fire && homing_ff) begin
         toggle = 1'b1;
         if (req.home_switch) begin
            homing_in = 1'b0;
            enabled   = 1'b1;
         end
      end

      // Detent requests in fixed order, the top detent only upward
      for (int k = 0; k < sdp_pkg::MASK_W; k++) begin
         slot = sdp_pkg::SLOT_W'(k);
         if (fire && !homing_in && pending_ff[slot]) begin
            svc = sdp_pkg::service_step(position_in, tgt[slot], k != sdp_pkg::MASK_W - 1);
            position_in = svc.position;
            if (svc.moved) begin
               toggle = ~toggle;
               dir_in = svc.descend;
            end
            if (svc.arrived) begin
               enabled          = 1'b1;
               pending_in[slot] = 1'b0;
            end
         end
      end

      level_in = level_ff ^ toggle;

      rsp_in.step_toggle  = toggle;
      rsp_in.step_level   = level_in;
      rsp_in.direction    = dir_in;
      rsp_in.enable_pulse = enabled;
      rsp_in.position     = sdp_pkg::TARGET_W'(position_in);
      rsp_in.pending      = pending_in;
      rsp_in.homing       = homing_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         position_ff <= '0;
         pending_ff  <= '0;
         homing_ff   <= 1'b1;
         dir_ff      <= 1'b0;
         level_ff    <= 1'b0;
      end else if (process) begin
         prescale_ff <= prescale_in;
         position_ff <= position_in;
         pending_ff  <= pending_in;
         homing_ff   <= homing_in;
         dir_ff      <= dir_in;
         level_ff    <= level_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hw/rtl/stepper_detent_positioner.sv @@
// ----------------------------------------------------------------------------
// stepper_detent_positioner: brake actuator stepper positioner
// Request register, core step logic and response register, plus APB registers.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake            | content
//   ----------+-----------+----------------------+--------------------------------
//   req_if    | in        | valid/ready          | operation, request_mask, home_switch
//   rsp_if    | out       | valid/ready          | step and position status
//   psel..    | in/out    | APB, pready always 1 | step_period, three targets
//
// One request per clock while the response is not stalled; each request yields one
// response after acceptance, through the request register, then the response register.
// Reset is synchronous: both stages empty, registers back to reset values.
// A stalled response holds the response register; the request register still
// takes one more request, then ready drops until the response moves on.
// ----------------------------------------------------------------------------
module stepper_detent_positioner (
   input  logic                       clock,
   input  logic                       reset,
   sdp_req_if.sink                    req_if,
   sdp_rsp_if.source                  rsp_if,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sdp_pkg::ADDR_W-1:0] paddr,
   input  logic [sdp_pkg::DATA_W-1:0] pwdata,
   output logic [sdp_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   sdp_pkg::cfg_type  cfg;
   sdp_pkg::ctrl_type ctrl;
   sdp_pkg::req_type  req_ff;
   sdp_pkg::rsp_type  rsp;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic              req_accept;

   // Handshake
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.operation    <= req_if.operation;
         req_ff.request_mask <= req_if.request_mask;
         req_ff.home_switch  <= req_if.home_switch;
      end
   end

   assign ctrl.in_valid = in_valid_ff;
   assign ctrl.advance  = advance;

   sdp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdp_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .ctrl  (ctrl),
      .req   (req_ff),
      .rsp   (rsp)
   );

   // Response outputs
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.step_toggle  = rsp.step_toggle;
   assign rsp_if.step_level   = rsp.step_level;
   assign rsp_if.direction    = rsp.direction;
   assign rsp_if.enable_pulse = rsp.enable_pulse;
   assign rsp_if.position     = rsp.position;
   assign rsp_if.pending      = rsp.pending;
   assign rsp_if.homing       = rsp.homing;

endmodule

@@ hw/rtl/sdp_checker.sv @@
// ----------------------------------------------------------------------------
// sdp_checker: port-level checks for the stepper detent positioner
// Bound to the top level; watches handshake and response fields over time.
// ----------------------------------------------------------------------------
module sdp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_enable_pulse,
   input logic                         rsp_direction,
   input logic                         rsp_homing,
   input logic [sdp_pkg::TARGET_W-1:0] rsp_position
);

   // Both stages empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // Stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("stalled response changed");

   // No enable pulse while still homing
   a_no_enable_homing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_homing |-> !rsp_enable_pulse)
      else $error("enable pulse during homing");

   // No motion before homing completes
   a_home_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_homing |-> rsp_position == '0 && !rsp_direction)
      else $error("position moved during homing");

endmodule

bind stepper_detent_positioner sdp_checker u_sdp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_enable_pulse (rsp_if.enable_pulse),
   .rsp_direction    (rsp_if.direction),
   .rsp_homing       (rsp_if.homing),
   .rsp_position     (rsp_if.position)
);
